/* hw/rtl/mec_pkg.sv */
package mec_pkg;

    // configuration register indexes
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_X = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_STEP_X   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_STEP_Y   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_ITER = 3'd4;

    // reset values, Q4.27
    localparam logic signed [31:0] ORIGIN_RESET   = 32'shF000_0000;
    localparam logic signed [31:0] STEP_RESET     = 32'sh0008_0000;
    localparam logic [15:0]        MAX_ITER_RESET = 16'd100;

    // bail-out box edges, +/-2.0 in Q4.27
    localparam logic signed [31:0] TWO_Q     = 32'sh1000_0000;
    localparam logic signed [31:0] NEG_TWO_Q = 32'shF000_0000;

    localparam logic signed [47:0] SAT_HI = 48'sh0000_7FFF_FFFF;
    localparam logic signed [47:0] SAT_LO = 48'shFFFF_8000_0000;

    typedef enum logic [2:0] {
        S_IDLE,
        S_COORD,
        S_SQUARE,
        S_UPDATE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic accept;      // latch grid products for a new item
        logic coord;       // form c, clear z and the step count
        logic square;      // register x*x, y*y, x*y
        logic update;      // z = z*z + c, count the step
        logic load_result; // move the count into the output register
    } t_cmd;

    typedef struct packed {
        logic cont;        // inside the box and below the limit
    } t_status;

    function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
        logic signed [31:0] r;
        if (v > SAT_HI) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < SAT_LO) begin
            r = 32'sh8000_0000;
        end else begin
            r = $signed(v[31:0]);
        end
        return r;
    endfunction

endpackage

/* hw/rtl/mec_cfg_regs.sv */
module mec_cfg_regs (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [mec_pkg::CFG_INDEX_W-1:0]      i_cfg_index,
    input  logic [mec_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    output logic signed [31:0]                   o_origin_x,
    output logic signed [31:0]                   o_origin_y,
    output logic signed [31:0]                   o_step_x,
    output logic signed [31:0]                   o_step_y,
    output logic [15:0]                          o_max_iterations
);

    logic signed [31:0] r_origin_x;
    logic signed [31:0] r_origin_y;
    logic signed [31:0] r_step_x;
    logic signed [31:0] r_step_y;
    logic [15:0]        r_max_iterations;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x       <= mec_pkg::ORIGIN_RESET;
            r_origin_y       <= mec_pkg::ORIGIN_RESET;
            r_step_x         <= mec_pkg::STEP_RESET;
            r_step_y         <= mec_pkg::STEP_RESET;
            r_max_iterations <= mec_pkg::MAX_ITER_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                mec_pkg::REG_ORIGIN_X: r_origin_x       <= $signed(i_cfg_data);
                mec_pkg::REG_ORIGIN_Y: r_origin_y       <= $signed(i_cfg_data);
                mec_pkg::REG_STEP_X:   r_step_x         <= $signed(i_cfg_data);
                mec_pkg::REG_STEP_Y:   r_step_y         <= $signed(i_cfg_data);
                mec_pkg::REG_MAX_ITER: r_max_iterations <= i_cfg_data[15:0];
                default: begin
                    // unknown index, write dropped
                end
            endcase
        end
    end

    assign o_origin_x       = r_origin_x;
    assign o_origin_y       = r_origin_y;
    assign o_step_x         = r_step_x;
    assign o_step_y         = r_step_y;
    assign o_max_iterations = r_max_iterations;

endmodule

/* hw/rtl/mec_datapath.sv */
module mec_datapath (
    input  logic                i_clk,
    input  mec_pkg::t_cmd       i_cmd,
    output mec_pkg::t_status    o_status,
    input  logic [9:0]          i_column,
    input  logic [9:0]          i_row,
    input  logic signed [31:0]  i_origin_x,
    input  logic signed [31:0]  i_origin_y,
    input  logic signed [31:0]  i_step_x,
    input  logic signed [31:0]  i_step_y,
    input  logic [15:0]         i_max_iterations,
    output logic [15:0]         o_escape_count
);

    logic signed [42:0] r_px;
    logic signed [42:0] r_py;
    logic signed [31:0] r_cx;
    logic signed [31:0] r_cy;
    logic signed [31:0] r_x;
    logic signed [31:0] r_y;
    logic signed [63:0] r_xx;
    logic signed [63:0] r_yy;
    logic signed [63:0] r_xy;
    logic [15:0]        r_k;
    logic [15:0]        r_escape_count;

    logic signed [42:0] n_px;
    logic signed [42:0] n_py;
    logic signed [43:0] w_sum_x;
    logic signed [43:0] w_sum_y;
    logic signed [64:0] w_diff;
    logic signed [37:0] w_re;
    logic signed [37:0] w_im;
    logic signed [31:0] n_x;
    logic signed [31:0] n_y;
    logic               w_inside;
    logic [15:0]        n_escape_count;

    // index is unsigned, so widen with a zero before the signed multiply
    assign n_px = 43'($signed({1'b0, i_column})) * 43'(i_step_x);
    assign n_py = 43'($signed({1'b0, i_row})) * 43'(i_step_y);

    assign w_sum_x = 44'(i_origin_x) + 44'(r_px);
    assign w_sum_y = 44'(i_origin_y) + 44'(r_py);

    // floor shifts fall out of dropping the low bits of two's complement
    assign w_diff = 65'(r_xx) - 65'(r_yy);
    assign w_re   = $signed(w_diff[64:27]);
    assign w_im   = $signed(r_xy[63:26]);
    assign n_x    = mec_pkg::sat32(48'(w_re) + 48'(r_cx));
    assign n_y    = mec_pkg::sat32(48'(w_im) + 48'(r_cy));

    assign w_inside = (r_x > mec_pkg::NEG_TWO_Q) && (r_x < mec_pkg::TWO_Q) &&
                      (r_y > mec_pkg::NEG_TWO_Q) && (r_y < mec_pkg::TWO_Q);

    assign o_status.cont = (r_k < i_max_iterations) && w_inside;

    // count holds steps done; the result is the index of the last one
    assign n_escape_count = (r_k == 16'd0) ? 16'd0 : (r_k - 16'd1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_px <= n_px;
            r_py <= n_py;
        end
        if (i_cmd.coord) begin
            r_cx <= mec_pkg::sat32(48'(w_sum_x));
            r_cy <= mec_pkg::sat32(48'(w_sum_y));
            r_x  <= '0;
            r_y  <= '0;
            r_k  <= '0;
        end
        if (i_cmd.square) begin
            r_xx <= 64'(r_x) * 64'(r_x);
            r_yy <= 64'(r_y) * 64'(r_y);
            r_xy <= 64'(r_x) * 64'(r_y);
        end
        if (i_cmd.update) begin
            r_x <= n_x;
            r_y <= n_y;
            r_k <= r_k + 16'd1;
        end
        if (i_cmd.load_result) begin
            r_escape_count <= n_escape_count;
        end
    end

    assign o_escape_count = r_escape_count;

endmodule

/* hw/rtl/mec_ctrl.sv */
module mec_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    output logic                o_valid,
    input  logic                i_stall,
    input  mec_pkg::t_status    i_status,
    output mec_pkg::t_cmd       o_cmd
);

    mec_pkg::t_state r_state;
    mec_pkg::t_state n_state;
    logic            r_out_valid;
    logic            n_out_valid;
    logic            w_out_free;

    assign w_out_free = !r_out_valid || !i_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            mec_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_state = mec_pkg::S_COORD;
                end
            end
            mec_pkg::S_COORD: begin
                n_state = mec_pkg::S_SQUARE;
            end
            mec_pkg::S_SQUARE: begin
                if (i_status.cont) begin
                    n_state = mec_pkg::S_UPDATE;
                end else begin
                    n_state = mec_pkg::S_DONE;
                end
            end
            mec_pkg::S_UPDATE: begin
                n_state = mec_pkg::S_SQUARE;
            end
            mec_pkg::S_DONE: begin
                if (w_out_free) begin
                    n_state = mec_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mec_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_stall = 1'b1;
        case (r_state)
            mec_pkg::S_IDLE: begin
                o_stall      = 1'b0;
                o_cmd.accept = i_valid;
            end
            mec_pkg::S_COORD: begin
                o_cmd.coord = 1'b1;
            end
            mec_pkg::S_SQUARE: begin
                o_cmd.square = i_status.cont;
            end
            mec_pkg::S_UPDATE: begin
                o_cmd.update = 1'b1;
            end
            mec_pkg::S_DONE: begin
                o_cmd.load_result = w_out_free;
            end
            default: begin
                o_stall = 1'b1;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_result) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mec_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_valid = r_out_valid;

`ifndef SYNTHESIS
    a_accept_starts_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mec_pkg::S_IDLE && i_valid) |=> (r_state == mec_pkg::S_COORD))
        else $error("accepted item did not start coordinate set-up");

    a_load_needs_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_result |-> (!r_out_valid || !i_stall))
        else $error("result loaded over an untaken result");

    a_valid_rises_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == mec_pkg::S_DONE))
        else $error("result shown without finishing an item");

    a_update_after_square: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mec_pkg::S_UPDATE) |-> ($past(r_state) == mec_pkg::S_SQUARE))
        else $error("update without registered products");
`endif

endmodule

/* hw/rtl/mandelbrot_escape_count.sv */
// Escape-time count for one point of a grid: an item names a column and row,
// the block forms c = origin + index * step in signed Q4.27, iterates
// z = z*z + c from zero while both parts of z stay inside (-2, 2), for at most
// max_iterations steps, and returns the index of the last step performed.
// One item is worked at a time. Each step of an item is a pass through the
// shared set of three 32x32 multipliers in the square state and then subtract,
// shift, add and saturate in the update state, with the coordinate state before
// the steps to form c, a last square state to test the final bail-out and the
// done state to load the output register. A finished count waits in that output
// register, so the next item is taken while the previous count is still stalled.
// Configuration writes belong to idle time.
module mandelbrot_escape_count (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [mec_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [mec_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [9:0]                       i_column,
    input  logic [9:0]                       i_row,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [15:0]                      o_escape_count
);

    logic signed [31:0] w_origin_x;
    logic signed [31:0] w_origin_y;
    logic signed [31:0] w_step_x;
    logic signed [31:0] w_step_y;
    logic [15:0]        w_max_iterations;
    mec_pkg::t_cmd      w_cmd;
    mec_pkg::t_status   w_status;

    mec_cfg_regs u_cfg_regs (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_origin_x       (w_origin_x),
        .o_origin_y       (w_origin_y),
        .o_step_x         (w_step_x),
        .o_step_y         (w_step_y),
        .o_max_iterations (w_max_iterations)
    );

    mec_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    mec_datapath u_datapath (
        .i_clk            (i_clk),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .i_column         (i_column),
        .i_row            (i_row),
        .i_origin_x       (w_origin_x),
        .i_origin_y       (w_origin_y),
        .i_step_x         (w_step_x),
        .i_step_y         (w_step_y),
        .i_max_iterations (w_max_iterations),
        .o_escape_count   (o_escape_count)
    );

endmodule

/* tb/mandelbrot_escape_count_test.sv */
`timescale 1ns / 1ps

module mandelbrot_escape_count_test;

    localparam int unsigned CYCLE_LIMIT   = 4_000_000;
    localparam int unsigned HOLD_CYCLES   = 2000;
    localparam int unsigned SETTLE_CYCLES = 16;
    localparam int unsigned PHASES        = 8;
    localparam int unsigned PHASE_ITEMS   = 128;
    localparam int unsigned MAX_GAP       = 16;

    typedef enum int {
        VIEW_FULL,
        VIEW_ZOOM,
        VIEW_NOISE,
        VIEW_EDGE
    } t_view;

    class escape_tracker;
        localparam longint BOX_EDGE = 64'sd1 << 28;

        logic signed [31:0] org_x;
        logic signed [31:0] org_y;
        logic signed [31:0] stp_x;
        logic signed [31:0] stp_y;
        logic [15:0]        iter_limit;
        logic [15:0]        counts_due[$];
        int                 errors;

        function new();
            org_x      = 32'shF000_0000;
            org_y      = 32'shF000_0000;
            stp_x      = 32'sh0008_0000;
            stp_y      = 32'sh0008_0000;
            iter_limit = 16'd100;
            errors     = 0;
        endfunction

        function void set_reg(input logic [mec_pkg::CFG_INDEX_W-1:0] idx,
                              input logic [31:0] data);
            case (idx)
                mec_pkg::REG_ORIGIN_X: org_x = data;
                mec_pkg::REG_ORIGIN_Y: org_y = data;
                mec_pkg::REG_STEP_X:   stp_x = data;
                mec_pkg::REG_STEP_Y:   stp_y = data;
                mec_pkg::REG_MAX_ITER: iter_limit = data[15:0];
                default: ;
            endcase
        endfunction

        function longint clamp_q(input longint v);
            if (v > 64'sd2147483647) begin
                return 64'sd2147483647;
            end
            if (v < -64'sd2147483648) begin
                return -64'sd2147483648;
            end
            return v;
        endfunction

        function logic [15:0] escape_index(input logic [9:0] col, input logic [9:0] row);
            longint      cx;
            longint      cy;
            longint      x;
            longint      y;
            longint      re;
            longint      im;
            int unsigned k;
            logic [15:0] last;
            cx   = clamp_q(longint'(org_x) + longint'(col) * longint'(stp_x));
            cy   = clamp_q(longint'(org_y) + longint'(row) * longint'(stp_y));
            x    = 0;
            y    = 0;
            last = '0;
            for (k = 0; k < iter_limit; k++) begin
                if (x <= -BOX_EDGE || x >= BOX_EDGE || y <= -BOX_EDGE || y >= BOX_EDGE) begin
                    break;
                end
                // arithmetic shift of a signed value floors, as the datapath does
                re   = (x * x - y * y) >>> 27;
                im   = (x * y) >>> 26;
                x    = clamp_q(re + cx);
                y    = clamp_q(im + cy);
                last = k[15:0];
            end
            return last;
        endfunction

        function void note_point(input logic [9:0] col, input logic [9:0] row);
            counts_due.push_back(escape_index(col, row));
        endfunction

        function void check_count(input logic [15:0] got);
            logic [15:0] want;
            if (counts_due.size() == 0) begin
                $display("%0t: escape count %0d arrived, expected none", $time, got);
                errors++;
            end else begin
                want = counts_due.pop_front();
                if (got !== want) begin
                    $display("%0t: escape count mismatch, expected %0d, got %0d",
                             $time, want, got);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return counts_due.size();
        endfunction
    endclass

    logic                            i_clk       = 1'b0;
    logic                            i_rst_n     = 1'b0;
    logic                            i_cfg_we    = 1'b0;
    logic [mec_pkg::CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [mec_pkg::CFG_DATA_W-1:0]  i_cfg_data  = '0;
    logic                            i_valid     = 1'b0;
    logic                            o_stall;
    logic [9:0]                      i_column    = '0;
    logic [9:0]                      i_row       = '0;
    logic                            o_valid;
    logic                            i_stall     = 1'b0;
    logic [15:0]                     o_escape_count;

    escape_tracker tracker = new();

    logic        send_idle    = 1'b0;
    logic        recv_idle    = 1'b0;
    logic        holding      = 1'b0;
    int unsigned stall_left   = 0;
    int unsigned results_seen = 0;
    int unsigned cycles       = 0;

    mandelbrot_escape_count u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_column       (i_column),
        .i_row          (i_row),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_escape_count (o_escape_count)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("** mandelbrot_escape_count: FAILED **");
            $finish;
        end
    end

    // result side: check each accepted count, then hold off for a drawn number of cycles when recv_idle is set
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                tracker.check_count(o_escape_count);
                results_seen++;
                stall_left = recv_idle ? $urandom_range(MAX_GAP, 0) : 0;
            end else if (stall_left > 0) begin
                stall_left--;
            end
            i_stall <= (stall_left > 0) || holding;
        end
    end

    // one long hold-off so the block fills up and pushes back on its input
    initial begin
        wait (results_seen >= 60);
        @(posedge i_clk);
        holding <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        holding <= 1'b0;
    end

    task automatic cfg_write(input logic [mec_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [31:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        tracker.set_reg(idx, data);
        @(posedge i_clk);
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_view(input logic [31:0] ox, input logic [31:0] oy,
                            input logic [31:0] sx, input logic [31:0] sy,
                            input logic [31:0] lim);
        settle();
        cfg_write(mec_pkg::REG_ORIGIN_X, ox);
        cfg_write(mec_pkg::REG_ORIGIN_Y, oy);
        cfg_write(mec_pkg::REG_STEP_X, sx);
        cfg_write(mec_pkg::REG_STEP_Y, sy);
        cfg_write(mec_pkg::REG_MAX_ITER, lim);
    endtask

    task automatic send_point(input logic [9:0] col, input logic [9:0] row);
        int unsigned gap;
        gap = send_idle ? $urandom_range(MAX_GAP, 0) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_column <= col;
        i_row    <= row;
        do @(posedge i_clk); while (o_stall);
        tracker.note_point(col, row);
    endtask

    function automatic logic [31:0] edge_value();
        case ($urandom_range(3, 0))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            default: return $urandom();
        endcase
    endfunction

    initial begin
        int unsigned ph;
        int unsigned n;
        int unsigned u;
        t_view       view;
        int          ox;
        int          oy;
        int          sx;
        int          sy;
        logic [15:0] lim;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset view: corners, centre and alternating bit patterns
        send_point(10'd0, 10'd0);
        send_point(10'd512, 10'd512);
        send_point(10'd1023, 10'd1023);
        send_point(10'd1023, 10'd0);
        send_point(10'd0, 10'd1023);
        send_point(10'h155, 10'h2AA);
        send_point(10'h2AA, 10'h155);
        send_point(10'd384, 10'd600);

        // zero limit, upper data bits ignored
        settle();
        cfg_write(mec_pkg::REG_MAX_ITER, 32'hFFFF_0000);
        send_point(10'd512, 10'd512);
        send_point(10'd0, 10'd0);

        settle();
        cfg_write(mec_pkg::REG_MAX_ITER, 32'h0000_0001);
        send_point(10'd512, 10'd512);
        send_point(10'd1023, 10'd1023);

        // writes to unmapped indexes must leave the view alone
        settle();
        cfg_write(mec_pkg::REG_MAX_ITER, 32'd100);
        for (u = mec_pkg::REG_MAX_ITER + 1; u < 2 ** mec_pkg::CFG_INDEX_W; u++) begin
            cfg_write(u[mec_pkg::CFG_INDEX_W-1:0], $urandom());
        end
        send_point(10'd512, 10'd512);
        send_point(10'd100, 10'd700);

        // grid coordinates saturating high and low
        set_view(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'd100);
        send_point(10'd0, 10'd0);
        send_point(10'd1023, 10'd1023);
        send_point(10'd1, 10'd1);
        set_view(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'd100);
        send_point(10'd1023, 10'd1023);
        send_point(10'd0, 10'd0);

        // c = 0 never escapes, so this runs to the full limit
        set_view(32'h0, 32'h0, 32'h100, 32'h100, 32'd65535);
        send_point(10'd0, 10'd0);

        for (ph = 0; ph < PHASES; ph++) begin
            case (ph)
                3:       view = VIEW_NOISE;
                6:       view = VIEW_EDGE;
                default: view = (ph % 2 == 1) ? VIEW_ZOOM : VIEW_FULL;
            endcase
            case (view)
                VIEW_FULL: begin
                    ox = -268435456;
                    oy = -268435456;
                    sx = 524288 - int'($urandom_range(4096, 0));
                    sy = 524288 - int'($urandom_range(4096, 0));
                end
                VIEW_ZOOM: begin
                    // window somewhere over the set and its boundary
                    ox = -268435456 + int'($urandom_range(301989888, 0));
                    oy = -167772160 + int'($urandom_range(301989888, 0));
                    sx = int'($urandom_range(524288, 256));
                    sy = int'($urandom_range(524288, 256));
                    if ($urandom_range(1, 0) == 1) begin
                        sy = -sy;
                    end
                end
                VIEW_NOISE: begin
                    ox = $urandom();
                    oy = $urandom();
                    sx = $urandom();
                    sy = $urandom();
                end
                default: begin
                    ox = edge_value();
                    oy = edge_value();
                    sx = edge_value();
                    sy = edge_value();
                end
            endcase
            lim = ($urandom_range(7, 0) == 0) ? 16'd1 : 16'($urandom_range(300, 2));
            send_idle = (ph != 2) && ($urandom_range(3, 0) != 0);
            recv_idle = (ph != 2) && ($urandom_range(3, 0) != 0);
            set_view(ox, oy, sx, sy, {16'($urandom()), lim});
            if ($urandom_range(1, 0) == 1) begin
                u = $urandom_range(2 ** mec_pkg::CFG_INDEX_W - 1, mec_pkg::REG_MAX_ITER + 1);
                cfg_write(u[mec_pkg::CFG_INDEX_W-1:0], $urandom());
            end
            for (n = 0; n < PHASE_ITEMS; n++) begin
                send_point(10'($urandom_range(1023, 0)), 10'($urandom_range(1023, 0)));
            end
        end

        settle();
        if (tracker.errors == 0) begin
            $display("** mandelbrot_escape_count: PASSED **");
        end else begin
            $display("** mandelbrot_escape_count: FAILED **");
        end
        $finish;
    end

endmodule
